FILE: design/bba_pkg.sv
// Shared constants and helpers for the bitmap block allocator.
// Used by the top level; no dependencies.

package bba_pkg;

	localparam int NUM_BLOCKS_DEF = 4096;
	localparam int WORD_BITS      = 64;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic REG_ENABLED      = 1'b0;
	localparam logic REG_FIRST_USABLE = 1'b1;

	localparam logic [11:0] FIRST_USABLE_RST = 12'd35;

	// Returns {found, position} of the lowest clear bit in a map word.
	function automatic logic [6:0] find_zero(input logic [63:0] w);
		logic [6:0] r;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			if (!w[i]) begin
				r = {1'b1, 6'(i)};
			end
		end
		return r;
	endfunction

endpackage

FILE: design/bba_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package dependencies.

module bba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/bitmap_block_allocator_top.sv
// Bitmap first-fit block allocator: usage map in a 64-bit wide RAM, one word per cycle scan.
// Depends on bba_pkg and bba_ram.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+------------------------------------------------
//  request   | start, busy           | operation, block_index
//  result    | done (one-cycle)      | status, granted_block, was_already_free,
//            |                       | allocated_count
//  config    | cfg_valid, cfg_ready  | cfg_index, cfg_data
//
// An allocate scans map words from the one holding the first usable block, at most
// NUM_BLOCKS/64 of them; the RAM read port delivers one word per cycle.
// A free reads the word holding its block and clears the bit; a rejected or disabled
// request is done in the next cycle. After reset a clearing pass writes all NUM_BLOCKS/64
// words with busy high; configuration writes are always taken.
// The result receiver cannot stall; a new request may be started in the done cycle.

module bitmap_block_allocator_top #(
	parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [11:0] block_index,
	output logic        done,
	output logic [1:0]  status,
	output logic [11:0] granted_block,
	output logic        was_already_free,
	output logic [12:0] allocated_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data
);

	localparam int WORDS = (NUM_BLOCKS + bba_pkg::WORD_BITS - 1) / bba_pkg::WORD_BITS;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int TAIL  = NUM_BLOCKS % bba_pkg::WORD_BITS;
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
	localparam int CXW   = (CNT_W > 13) ? CNT_W : 13;
	localparam int XW    = ($clog2(NUM_BLOCKS) > 12) ? $clog2(NUM_BLOCKS) + 1 : 13;
	localparam int GXW   = (AW + 6 > 12) ? AW + 6 : 12;
	localparam logic [AW-1:0] LAST = AW'(WORDS - 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CLEAR = 4'b0010,
		S_ALLOC = 4'b0100,
		S_FREE  = 4'b1000
	} state_t;

	state_t           state_q;
	logic [AW-1:0]    addr_q;
	logic [AW-1:0]    chk_addr_q;
	logic             chk_valid_q;
	logic [AW-1:0]    start_w_q;
	logic [5:0]       idx_lo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             enabled_q;
	logic [11:0]      first_q;
	logic             done_q;
	logic [1:0]       status_q;
	logic [11:0]      granted_q;
	logic             already_q;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [63:0]      mem_wdata;
	logic [63:0]      rd_data;
	logic [63:0]      mask;
	logic [6:0]       zero_hit;
	logic [GXW-1:0]   blk_x;
	logic [CXW-1:0]   cnt_x;
	logic [XW-1:0]    first_x;
	logic [XW-1:0]    idx_x;
	logic             accept;
	logic             last_word;
	logic             free_bit;

	bba_ram #(
		.WIDTH(bba_pkg::WORD_BITS),
		.DEPTH(WORDS)
	) u_map (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(addr_q),
		.rdata(rd_data)
	);

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign first_x   = XW'(first_q);
	assign idx_x     = XW'(block_index);
	assign last_word = (chk_addr_q == LAST);
	assign free_bit  = rd_data[idx_lo_q];

	// Blocks below the first usable one and past the end of the map look used to the scan.
	always_comb begin
		mask = '0;
		for (int j = 0; j < 64; j++) begin
			if (chk_addr_q == start_w_q && j < int'(first_q[5:0])) begin
				mask[j] = 1'b1;
			end
			if (last_word && TAIL != 0 && j >= TAIL) begin
				mask[j] = 1'b1;
			end
		end
	end

	assign zero_hit = bba_pkg::find_zero(rd_data | mask);
	assign blk_x    = GXW'({chk_addr_q, zero_hit[5:0]});

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = chk_addr_q;
		mem_wdata = rd_data;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = addr_q;
				mem_wdata = '0;
			end
			S_ALLOC: begin
				mem_we    = chk_valid_q && zero_hit[6];
				mem_wdata = rd_data | (64'd1 << zero_hit[5:0]);
			end
			S_FREE: begin
				mem_we    = chk_valid_q && free_bit;
				mem_wdata = rd_data & ~(64'd1 << idx_lo_q);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			first_q   <= bba_pkg::FIRST_USABLE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bba_pkg::REG_ENABLED:      enabled_q <= cfg_data[0];
				bba_pkg::REG_FIRST_USABLE: first_q   <= cfg_data;
				default:                   enabled_q <= enabled_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			addr_q      <= '0;
			chk_addr_q  <= '0;
			chk_valid_q <= 1'b0;
			start_w_q   <= '0;
			idx_lo_q    <= '0;
			cnt_q       <= '0;
			done_q      <= 1'b0;
			status_q    <= bba_pkg::ST_OK;
			granted_q   <= '0;
			already_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (addr_q == LAST) begin
						addr_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				S_IDLE: begin
					chk_valid_q <= 1'b0;
					if (accept) begin
						granted_q <= '0;
						already_q <= 1'b0;
						if (!enabled_q) begin
							done_q   <= 1'b1;
							status_q <= bba_pkg::ST_INVALID;
						end else if (operation == bba_pkg::OP_ALLOC) begin
							if (first_x >= XW'(NUM_BLOCKS)) begin
								done_q   <= 1'b1;
								status_q <= bba_pkg::ST_NOSPACE;
							end else begin
								addr_q    <= AW'(first_q >> 6);
								start_w_q <= AW'(first_q >> 6);
								state_q   <= S_ALLOC;
							end
						end else begin
							if (block_index < first_q || idx_x >= XW'(NUM_BLOCKS)) begin
								done_q   <= 1'b1;
								status_q <= bba_pkg::ST_INVALID;
							end else begin
								addr_q   <= AW'(block_index >> 6);
								idx_lo_q <= block_index[5:0];
								state_q  <= S_FREE;
							end
						end
					end
				end
				S_ALLOC: begin
					// The read for the next word is issued while the current one is checked.
					chk_valid_q <= 1'b1;
					chk_addr_q  <= addr_q;
					if (addr_q != LAST) begin
						addr_q <= addr_q + AW'(1);
					end
					if (chk_valid_q) begin
						if (zero_hit[6]) begin
							done_q      <= 1'b1;
							status_q    <= bba_pkg::ST_OK;
							granted_q   <= blk_x[11:0];
							cnt_q       <= cnt_q + CNT_W'(1);
							chk_valid_q <= 1'b0;
							state_q     <= S_IDLE;
						end else if (last_word) begin
							done_q      <= 1'b1;
							status_q    <= bba_pkg::ST_NOSPACE;
							chk_valid_q <= 1'b0;
							state_q     <= S_IDLE;
						end
					end
				end
				S_FREE: begin
					chk_valid_q <= 1'b1;
					chk_addr_q  <= addr_q;
					if (chk_valid_q) begin
						done_q      <= 1'b1;
						status_q    <= bba_pkg::ST_OK;
						already_q   <= !free_bit;
						chk_valid_q <= 1'b0;
						state_q     <= S_IDLE;
						if (free_bit && cnt_q != '0) begin
							cnt_q <= cnt_q - CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cnt_x            = CXW'(cnt_q);
	assign done             = done_q;
	assign status           = status_q;
	assign granted_block    = granted_q;
	assign was_already_free = already_q;
	assign allocated_count  = cnt_x[12:0];

	a_write_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> busy)
		else $error("map written while idle");

	a_disabled_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !enabled_q) |=> (done && status == bba_pkg::ST_INVALID))
		else $error("disabled request not rejected next cycle");

	a_fail_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != bba_pkg::ST_OK) |-> (granted_block == '0 && !was_already_free))
		else $error("failed request carries a grant or flag");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(NUM_BLOCKS))
		else $error("allocated count exceeds map size");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result without a request");

endmodule

FILE: verif/bitmap_block_allocator_top_tb.sv
// Testbench for bitmap_block_allocator_top: allocate and free requests against a local
// usage-map predictor, with register writes between phases. Depends on bba_pkg and the RTL.
`timescale 1ns / 100ps

module bitmap_block_allocator_top_tb;

	localparam int NBLK = 4096;

	typedef struct packed {
		logic        op;
		logic [11:0] idx;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] grant;
		logic        already;
		logic [12:0] count;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        operation = bba_pkg::OP_ALLOC;
	logic [11:0] block_index = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_index = bba_pkg::REG_ENABLED;
	logic [11:0] cfg_data = '0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [11:0] granted_block;
	logic        was_already_free;
	logic [12:0] allocated_count;
	logic        cfg_ready;

	bitmap_block_allocator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.block_index(block_index),
		.done(done),
		.status(status),
		.granted_block(granted_block),
		.was_already_free(was_already_free),
		.allocated_count(allocated_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	request_t    req_q[$];
	outcome_t    outcome_q[$];
	bit          req_taken = 1'b0;
	int          gap_left = 0;
	int          gap_pct = 0;
	int          errors = 0;

	// Predictor state.
	bit          map_used [NBLK];
	logic [12:0] used_cnt = '0;
	logic        mounted = 1'b0;
	logic [11:0] first_blk = bba_pkg::FIRST_USABLE_RST;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("bitmap_block_allocator_top_tb: done, errors");
		$finish;
	end

	function automatic outcome_t predict_outcome(input logic op, input logic [11:0] idx);
		outcome_t o;
		bit found;
		o = '{status: bba_pkg::ST_INVALID, grant: '0, already: 1'b0, count: '0};
		found = 1'b0;
		if (mounted) begin
			if (op == bba_pkg::OP_ALLOC) begin
				o.status = bba_pkg::ST_NOSPACE;
				for (int b = first_blk; b < NBLK && !found; b++) begin
					if (!map_used[b]) begin
						found = 1'b1;
						map_used[b] = 1'b1;
						used_cnt = used_cnt + 13'd1;
						o.status = bba_pkg::ST_OK;
						o.grant = 12'(b);
					end
				end
			end else if (idx >= first_blk) begin
				o.status = bba_pkg::ST_OK;
				if (!map_used[idx]) begin
					o.already = 1'b1;
				end else begin
					map_used[idx] = 1'b0;
					if (used_cnt != 0) begin
						used_cnt = used_cnt - 13'd1;
					end
				end
			end
		end
		o.count = used_cnt;
		return o;
	endfunction

	task automatic check_field(input string fname, input logic [12:0] want, input logic [12:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
		end
	endtask

	// Monitor: results are compared before a request taken at the same edge is predicted.
	always @(posedge clk) begin : monitor
		outcome_t want;
		if (arst_n) begin
			if (done) begin
				if (outcome_q.size() == 0) begin
					errors++;
					$display("%0t: result with no request outstanding, status %0d", $time, status);
				end else begin
					want = outcome_q.pop_front();
					check_field("status", 13'(want.status), 13'(status));
					check_field("granted_block", 13'(want.grant), 13'(granted_block));
					check_field("was_already_free", 13'(want.already), 13'(was_already_free));
					check_field("allocated_count", want.count, allocated_count);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == bba_pkg::REG_ENABLED) begin
					mounted = cfg_data[0];
				end else begin
					first_blk = cfg_data;
				end
			end
			req_taken = start && !busy;
			if (req_taken) begin
				outcome_q.push_back(predict_outcome(operation, block_index));
			end
		end else begin
			req_taken = 1'b0;
		end
	end

	// Driver: holds a request until taken, then optionally idles for a burst.
	always @(negedge clk) begin : driver
		request_t r;
		if (arst_n && !(start && !req_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (req_q.size() > 0) begin
				r = req_q.pop_front();
				operation <= r.op;
				block_index <= r.idx;
				start <= 1'b1;
				if ($urandom_range(0, 99) < gap_pct) begin
					gap_left = $urandom_range(1, 9);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic push_req(input logic op, input logic [11:0] idx);
		req_q.push_back('{op: op, idx: idx});
	endtask

	task automatic write_reg(input logic ridx, input logic [11:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= ridx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (req_q.size() != 0 || start || outcome_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Frees mostly land near the bound, where first-fit allocations cluster.
	function automatic logic [11:0] pick_free_index(input int fu);
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			v = fu + $urandom_range(0, 80);
			if (v > NBLK - 1) begin
				v = $urandom_range(fu, NBLK - 1);
			end
		end else if (r < 85 || fu == 0) begin
			v = $urandom_range(0, NBLK - 1);
		end else begin
			v = $urandom_range(0, fu - 1);
		end
		return 12'(v);
	endfunction

	task automatic run_phase(input logic en, input int fu, input int n, input int alloc_pct,
			input int gaps);
		wait_drained();
		write_reg(bba_pkg::REG_ENABLED, 12'(en));
		write_reg(bba_pkg::REG_FIRST_USABLE, 12'(fu));
		gap_pct = gaps;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < alloc_pct) begin
				push_req(bba_pkg::OP_ALLOC, 12'($urandom));
			end else begin
				push_req(bba_pkg::OP_FREE, pick_free_index(fu));
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Disabled after reset: everything is rejected.
		gap_pct = 30;
		push_req(bba_pkg::OP_ALLOC, 12'hFFF);
		push_req(bba_pkg::OP_FREE, 12'd0);
		push_req(bba_pkg::OP_FREE, 12'hFFF);
		push_req(bba_pkg::OP_FREE, 12'd35);
		wait_drained();

		// Reset bound of 35: below it is metadata.
		write_reg(bba_pkg::REG_ENABLED, 12'd1);
		push_req(bba_pkg::OP_ALLOC, 12'd0);
		push_req(bba_pkg::OP_ALLOC, 12'hFFF);
		push_req(bba_pkg::OP_FREE, 12'd34);
		push_req(bba_pkg::OP_FREE, 12'd35);
		push_req(bba_pkg::OP_FREE, 12'd35);
		push_req(bba_pkg::OP_ALLOC, 12'd0);
		push_req(bba_pkg::OP_FREE, 12'hFFF);
		push_req(bba_pkg::OP_FREE, 12'd0);
		push_req(bba_pkg::OP_ALLOC, 12'hFFF);
		wait_drained();

		// Bound at the top of the map: fills, reports no space, then strands block 36.
		write_reg(bba_pkg::REG_FIRST_USABLE, 12'd4094);
		push_req(bba_pkg::OP_ALLOC, 12'd0);
		push_req(bba_pkg::OP_ALLOC, 12'd0);
		push_req(bba_pkg::OP_ALLOC, 12'd0);
		push_req(bba_pkg::OP_FREE, 12'd4095);
		push_req(bba_pkg::OP_ALLOC, 12'd0);
		push_req(bba_pkg::OP_FREE, 12'd36);
		wait_drained();

		// Lowered bound makes the stranded block freeable again.
		write_reg(bba_pkg::REG_FIRST_USABLE, 12'd0);
		push_req(bba_pkg::OP_ALLOC, 12'd0);
		push_req(bba_pkg::OP_FREE, 12'd36);
		push_req(bba_pkg::OP_FREE, 12'd0);

		run_phase(1'b1, 0, 300, 60, 25);
		run_phase(1'b1, 4032, 250, 70, 0);
		run_phase(1'b1, 4095, 60, 50, 40);
		run_phase(1'b0, $urandom_range(0, 4095), 40, 50, 20);
		run_phase(1'b1, $urandom_range(36, 4000), 300, 55, 25);
		run_phase(1'b1, 35, 300, 50, 10);
		run_phase(1'b1, 4080, 200, 65, 30);
		run_phase(1'b1, $urandom_range(1, 63), 250, 55, 0);

		wait_drained();
		repeat (70) @(posedge clk);
		if (errors == 0) begin
			$display("bitmap_block_allocator_top_tb: done, clean");
		end else begin
			$display("bitmap_block_allocator_top_tb: done, errors");
		end
		$finish;
	end

endmodule
